/* rtl/wmpc_pkg.sv */
// Shared types and widths for the wall move permission check unit.
package wmpc_pkg;

    localparam int unsigned POS_W   = 32;
    localparam int unsigned DIR_W   = 16;
    localparam int unsigned LEN_W   = 31;
    localparam int unsigned RAD_W   = 31;
    localparam int unsigned IN_W    = 256;
    localparam int unsigned OUT_W   = 8;
    localparam int unsigned NSTG    = 8;

    typedef struct packed {
        logic                 pad;
        logic [LEN_W-1:0]     segment_length;
        logic [DIR_W-1:0]     dir_y;
        logic [DIR_W-1:0]     dir_x;
        logic [POS_W-1:0]     line_start_y;
        logic [POS_W-1:0]     line_start_x;
        logic [POS_W-1:0]     new_y;
        logic [POS_W-1:0]     new_x;
        logic [POS_W-1:0]     old_y;
        logic [POS_W-1:0]     old_x;
    } t_wall_item;

    typedef struct packed {
        logic [NSTG-1:0] load;
    } t_pipe_ctl;

endpackage

/* rtl/wmpc_datapath.sv */
// Eight-stage arithmetic pipeline for the wall move permission test.
module wmpc_datapath (
    input  logic                       i_clk,
    input  wmpc_pkg::t_pipe_ctl        i_ctl,
    input  wmpc_pkg::t_wall_item       i_item,
    input  logic [wmpc_pkg::RAD_W-1:0] i_body_radius,
    output logic                       o_move_allowed
);
    import wmpc_pkg::*;

    function automatic logic [34:0] mag_ed(input logic signed [34:0] v);
        return v[34] ? 35'(-v) : 35'(v);
    endfunction

    function automatic logic [49:0] mag_acc(input logic signed [49:0] v);
        return v[49] ? 50'(-v) : 50'(v);
    endfunction

    // stage 1
    logic signed [32:0] n1_ovx, n1_ovy, n1_nvx, n1_nvy;
    logic signed [47:0] n1_pex, n1_pey;
    logic signed [32:0] r1_ovx, r1_ovy, r1_nvx, r1_nvy;
    logic signed [47:0] r1_pex, r1_pey;
    logic signed [15:0] r1_dx, r1_dy;
    logic [LEN_W-1:0]   r1_len;

    assign n1_ovx = $signed({i_item.old_x[31], i_item.old_x})
                  - $signed({i_item.line_start_x[31], i_item.line_start_x});
    assign n1_ovy = $signed({i_item.old_y[31], i_item.old_y})
                  - $signed({i_item.line_start_y[31], i_item.line_start_y});
    assign n1_nvx = $signed({i_item.new_x[31], i_item.new_x})
                  - $signed({i_item.line_start_x[31], i_item.line_start_x});
    assign n1_nvy = $signed({i_item.new_y[31], i_item.new_y})
                  - $signed({i_item.line_start_y[31], i_item.line_start_y});
    assign n1_pex = 48'($signed(i_item.dir_x)) * 48'($signed({1'b0, i_item.segment_length}));
    assign n1_pey = 48'($signed(i_item.dir_y)) * 48'($signed({1'b0, i_item.segment_length}));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r1_ovx <= n1_ovx;
            r1_ovy <= n1_ovy;
            r1_nvx <= n1_nvx;
            r1_nvy <= n1_nvy;
            r1_pex <= n1_pex;
            r1_pey <= n1_pey;
            r1_dx  <= $signed(i_item.dir_x);
            r1_dy  <= $signed(i_item.dir_y);
            r1_len <= i_item.segment_length;
        end
    end

    // stage 2
    logic signed [48:0] n2_pxx, n2_pyy, n2_pyx, n2_pxy, n2_qyx, n2_qxy;
    logic signed [47:0] w2_rex, w2_rey;
    logic signed [48:0] r2_pxx, r2_pyy, r2_pyx, r2_pxy, r2_qyx, r2_qxy;
    logic signed [33:0] r2_ex, r2_ey;
    logic signed [32:0] r2_ovx, r2_ovy, r2_nvx, r2_nvy;
    logic [LEN_W-1:0]   r2_len;

    assign n2_pxx = 49'(r1_ovx) * 49'(r1_dx);
    assign n2_pyy = 49'(r1_ovy) * 49'(r1_dy);
    assign n2_pyx = 49'(r1_ovy) * 49'(r1_dx);
    assign n2_pxy = 49'(r1_ovx) * 49'(r1_dy);
    assign n2_qyx = 49'(r1_nvy) * 49'(r1_dx);
    assign n2_qxy = 49'(r1_nvx) * 49'(r1_dy);
    assign w2_rex = r1_pex + 48'sd8192;
    assign w2_rey = r1_pey + 48'sd8192;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r2_pxx <= n2_pxx;
            r2_pyy <= n2_pyy;
            r2_pyx <= n2_pyx;
            r2_pxy <= n2_pxy;
            r2_qyx <= n2_qyx;
            r2_qxy <= n2_qxy;
            r2_ex  <= $signed(w2_rex[47:14]);
            r2_ey  <= $signed(w2_rey[47:14]);
            r2_ovx <= r1_ovx;
            r2_ovy <= r1_ovy;
            r2_nvx <= r1_nvx;
            r2_nvy <= r1_nvy;
            r2_len <= r1_len;
        end
    end

    // stage 3
    logic signed [49:0] w3_proj, w3_len30, n3_d1, n3_d2;
    logic signed [34:0] n3_eox, n3_eoy, n3_enx, n3_eny;
    logic               n3_early;
    logic signed [49:0] r3_d1, r3_d2;
    logic signed [34:0] r3_v [8];
    logic               r3_early;

    assign w3_proj  = $signed({r2_pxx[48], r2_pxx}) + $signed({r2_pyy[48], r2_pyy});
    assign w3_len30 = $signed({5'b0, r2_len, 14'b0});
    assign n3_early = (w3_proj <= 50'sd0) || (w3_proj >= w3_len30);
    assign n3_d1    = $signed({r2_pyx[48], r2_pyx}) - $signed({r2_pxy[48], r2_pxy});
    assign n3_d2    = $signed({r2_qyx[48], r2_qyx}) - $signed({r2_qxy[48], r2_qxy});
    assign n3_eox   = $signed({{2{r2_ovx[32]}}, r2_ovx}) - $signed({r2_ex[33], r2_ex});
    assign n3_eoy   = $signed({{2{r2_ovy[32]}}, r2_ovy}) - $signed({r2_ey[33], r2_ey});
    assign n3_enx   = $signed({{2{r2_nvx[32]}}, r2_nvx}) - $signed({r2_ex[33], r2_ex});
    assign n3_eny   = $signed({{2{r2_nvy[32]}}, r2_nvy}) - $signed({r2_ey[33], r2_ey});

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r3_early <= n3_early;
            r3_d1    <= n3_d1;
            r3_d2    <= n3_d2;
            r3_v[0]  <= $signed({{2{r2_ovx[32]}}, r2_ovx});
            r3_v[1]  <= $signed({{2{r2_ovy[32]}}, r2_ovy});
            r3_v[2]  <= n3_eox;
            r3_v[3]  <= n3_eoy;
            r3_v[4]  <= $signed({{2{r2_nvx[32]}}, r2_nvx});
            r3_v[5]  <= $signed({{2{r2_nvy[32]}}, r2_nvy});
            r3_v[6]  <= n3_enx;
            r3_v[7]  <= n3_eny;
        end
    end

    // stage 4
    logic [34:0] r4_mag [8];
    logic [49:0] r4_ad1, r4_ad2;
    logic        r4_early, r4_side;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            for (int i = 0; i < 8; i++) begin
                r4_mag[i] <= mag_ed(r3_v[i]);
            end
            r4_ad1   <= mag_acc(r3_d1);
            r4_ad2   <= mag_acc(r3_d2);
            r4_side  <= ((r3_d1 > 50'sd0) == (r3_d2 > 50'sd0));
            r4_early <= r3_early;
        end
    end

    // stage 5
    logic [49:0] w5_rad30;
    logic [69:0] r5_sq [8];
    logic [61:0] r5_rsq;
    logic        r5_early, r5_side, r5_perp_ok;

    assign w5_rad30 = {5'b0, i_body_radius, 14'b0};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[4]) begin
            for (int i = 0; i < 8; i++) begin
                r5_sq[i] <= 70'(r4_mag[i]) * 70'(r4_mag[i]);
            end
            r5_rsq     <= 62'(i_body_radius) * 62'(i_body_radius);
            r5_perp_ok <= (r4_ad1 < r4_ad2) || (r4_ad2 > w5_rad30);
            r5_side    <= r4_side;
            r5_early   <= r4_early;
        end
    end

    // stage 6
    logic [70:0] r6_sum [4];
    logic [61:0] r6_rsq;
    logic        r6_early, r6_cond;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[5]) begin
            for (int i = 0; i < 4; i++) begin
                r6_sum[i] <= 71'(r5_sq[2*i]) + 71'(r5_sq[2*i+1]);
            end
            r6_rsq   <= r5_rsq;
            r6_cond  <= r5_side && r5_perp_ok;
            r6_early <= r5_early;
        end
    end

    // stage 7
    logic [70:0] r7_h_old, r7_h_new;
    logic [61:0] r7_rsq;
    logic        r7_early, r7_cond;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[6]) begin
            r7_h_old <= (r6_sum[0] < r6_sum[1]) ? r6_sum[0] : r6_sum[1];
            r7_h_new <= (r6_sum[2] < r6_sum[3]) ? r6_sum[2] : r6_sum[3];
            r7_rsq   <= r6_rsq;
            r7_cond  <= r6_cond;
            r7_early <= r6_early;
        end
    end

    // stage 8
    logic n8_ok;
    logic r8_allowed;

    assign n8_ok = r7_cond
                && ((r7_h_old < r7_h_new) || ({9'b0, r7_rsq} < r7_h_new));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[7]) begin
            r8_allowed <= r7_early || n8_ok;
        end
    end

    assign o_move_allowed = r8_allowed;

endmodule

/* rtl/wall_move_permission_check_unit.sv */
// Top level of the wall move permission check unit.
// Throughput: one beat per cycle while m_axis_tready is high; each stage holds
// on its own, so while a result waits the input keeps accepting until every
// stage is full, and bubbles upstream fill in.
// Reset (i_rst_n low, synchronous): clears all stage valids and sets
// body_radius to 16384 (0.25 in Q16.16).
module wall_move_permission_check_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [wmpc_pkg::RAD_W-1:0]    i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // old_x, old_y, new_x, new_y, line_start_x, line_start_y, dir_x, dir_y,
    // segment_length, zero pad
    input  logic [wmpc_pkg::IN_W-1:0]     s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // move_allowed, zero pad
    output logic [wmpc_pkg::OUT_W-1:0]    m_axis_tdata
);
    import wmpc_pkg::*;

    logic [RAD_W-1:0] r_body_radius;
    logic [NSTG-1:0]  r_vld;
    logic [NSTG-1:0]  n_vld;
    logic [NSTG:0]    stg_rdy;
    logic [NSTG-1:0]  stg_vin;
    t_pipe_ctl        pipe_ctl;
    t_wall_item       in_item;
    logic             move_allowed;

    assign in_item = t_wall_item'(s_axis_tdata);

    always_comb begin
        stg_rdy[NSTG] = m_axis_tready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            stg_rdy[k] = !r_vld[k] || stg_rdy[k+1];
        end
    end

    always_comb begin
        stg_vin[0] = s_axis_tvalid;
        for (int k = 1; k < NSTG; k++) begin
            stg_vin[k] = r_vld[k-1];
        end
        for (int k = 0; k < NSTG; k++) begin
            pipe_ctl.load[k] = stg_rdy[k];
            n_vld[k]         = stg_rdy[k] ? stg_vin[k] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld         <= '0;
            r_body_radius <= RAD_W'(16384);
        end else begin
            r_vld <= n_vld;
            if (i_cfg_we) begin
                r_body_radius <= i_cfg_wdata;
            end
        end
    end

    wmpc_datapath u_datapath (
        .i_clk          (i_clk),
        .i_ctl          (pipe_ctl),
        .i_item         (in_item),
        .i_body_radius  (r_body_radius),
        .o_move_allowed (move_allowed)
    );

    assign s_axis_tready = stg_rdy[0];
    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tdata  = {{(OUT_W-1){1'b0}}, move_allowed};

endmodule

/* rtl/wmpc_checker.sv */
// Port-level assertions for the wall move permission check unit.
module wmpc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result beat dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("result beat present right after reset");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output stage is empty");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output back-pressure");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'b0))
        else $error("result pad bits not zero");

endmodule

bind wall_move_permission_check_unit wmpc_checker u_wmpc_checker (.*);
